[sv/tecc_pkg.sv]
// Package for the TLS 1.3 extension capability checker.
// Holds phase enums, extension and group codes, and the transaction types.
// No dependencies.
`timescale 1ns / 1ps

package tecc_pkg;

  typedef enum logic [2:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_RLEN_HI,
    PH_RLEN_LO,
    PH_BODY,
    PH_DONE
  } parse_phase_t;

  typedef enum logic [2:0] {
    SH_LLEN_HI,
    SH_LLEN_LO,
    SH_GRP_HI,
    SH_GRP_LO,
    SH_KLEN_HI,
    SH_KLEN_LO,
    SH_KEY_FIRST,
    SH_KEY_REST
  } share_phase_t;

  localparam logic [15:0] EXT_SUPPORTED_GROUPS = 16'd10;
  localparam logic [15:0] EXT_POINT_FORMATS    = 16'd11;
  localparam logic [15:0] EXT_SUPPORTED_VERS   = 16'd43;
  localparam logic [15:0] EXT_PSK_MODES        = 16'd45;
  localparam logic [15:0] EXT_KEY_SHARE        = 16'd51;

  localparam logic [15:0] GROUP_SECP256R1 = 16'd23;
  localparam logic [15:0] GROUP_X25519    = 16'd29;

  localparam logic [7:0] POINT_UNCOMPRESSED = 8'd0;
  localparam logic [7:0] KEY_LEAD_BYTE      = 8'd4;
  localparam logic [7:0] VERSION_MAJOR      = 8'd3;
  localparam logic [7:0] VERSION_MINOR      = 8'd4;

  localparam int unsigned F_GROUP   = 0;
  localparam int unsigned F_FORMAT  = 1;
  localparam int unsigned F_VERSION = 2;
  localparam int unsigned F_PSK     = 3;
  localparam int unsigned F_SHARE   = 4;

  typedef logic [4:0] flags_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       block_start;
  } item_t;

  typedef struct packed {
    logic   valid;
    flags_t flags;
  } result_t;

endpackage

[sv/tecc_if.sv]
// Channel interfaces for the extension capability checker.
// Input channel carries extension bytes, output channel carries capability results.
// No dependencies.
`timescale 1ns / 1ps

interface tecc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface tecc_out_if;
  logic valid;
  logic ready;
  logic accept;
  logic group_ok;
  logic format_ok;
  logic version_ok;
  logic psk_mode_seen;
  logic share_ok;

  modport source (output valid, output accept, output group_ok, output format_ok,
                  output version_ok, output psk_mode_seen, output share_ok,
                  input ready);
  modport sink   (input valid, input accept, input group_ok, input format_ok,
                  input version_ok, input psk_mode_seen, input share_ok,
                  output ready);
endinterface

[sv/tecc_in_reg.sv]
// Input register stage of the extension capability checker.
// Depends on tecc_pkg and tecc_in_if.
`timescale 1ns / 1ps

module tecc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  tecc_in_if.sink       in_if,
  input  logic          adv,
  output tecc_pkg::item_t item
);
  import tecc_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       start_r;
  logic       take;

  assign in_if.ready = !valid_r || adv;
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r  <= in_if.data_byte;
      start_r <= in_if.block_start;
    end
  end

  assign item = '{valid: valid_r, data_byte: byte_r, block_start: start_r};

endmodule

[sv/tecc_parser.sv]
// Record walker: parse state, share-list walk and capability flags, one byte per cycle while adv.
// Depends on tecc_pkg.
`timescale 1ns / 1ps

module tecc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  tecc_pkg::item_t   item,
  input  logic              adv,
  output tecc_pkg::result_t res
);
  import tecc_pkg::*;

  parse_phase_t ph_r, ph_nxt;
  logic [15:0]  block_left_r, block_left_nxt;
  logic [15:0]  rec_type_r, rec_type_nxt;
  logic [15:0]  rec_left_r, rec_left_nxt;
  logic [1:0]   idx_cnt_r, idx_cnt_nxt;
  logic         idx_odd_r, idx_odd_nxt;
  logic [7:0]   held_r, held_nxt;
  share_phase_t sh_r, sh_nxt;
  logic [15:0]  list_left_r, list_left_nxt;
  logic [15:0]  grp_r, grp_nxt;
  logic [15:0]  key_left_r, key_left_nxt;
  logic         hit_r, hit_nxt;
  flags_t       flags_r, flags_nxt;
  logic         emit;
  logic         fire;
  logic [7:0]   b;

  assign fire = item.valid && adv;
  assign b    = item.data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_LEN_HI;
      block_left_r <= '0;
      rec_type_r   <= '0;
      rec_left_r   <= '0;
      idx_cnt_r    <= '0;
      idx_odd_r    <= 1'b0;
      held_r       <= '0;
      sh_r         <= SH_LLEN_HI;
      list_left_r  <= '0;
      grp_r        <= '0;
      key_left_r   <= '0;
      hit_r        <= 1'b0;
      flags_r      <= '0;
    end else if (fire) begin
      ph_r         <= ph_nxt;
      block_left_r <= block_left_nxt;
      rec_type_r   <= rec_type_nxt;
      rec_left_r   <= rec_left_nxt;
      idx_cnt_r    <= idx_cnt_nxt;
      idx_odd_r    <= idx_odd_nxt;
      held_r       <= held_nxt;
      sh_r         <= sh_nxt;
      list_left_r  <= list_left_nxt;
      grp_r        <= grp_nxt;
      key_left_r   <= key_left_nxt;
      hit_r        <= hit_nxt;
      flags_r      <= flags_nxt;
    end
  end

  always_comb begin
    ph_nxt         = ph_r;
    block_left_nxt = block_left_r;
    rec_type_nxt   = rec_type_r;
    rec_left_nxt   = rec_left_r;
    idx_cnt_nxt    = idx_cnt_r;
    idx_odd_nxt    = idx_odd_r;
    held_nxt       = held_r;
    sh_nxt         = sh_r;
    list_left_nxt  = list_left_r;
    grp_nxt        = grp_r;
    key_left_nxt   = key_left_r;
    hit_nxt        = hit_r;
    flags_nxt      = flags_r;
    emit           = 1'b0;

    if (item.block_start) begin
      ph_nxt         = PH_LEN_HI;
      block_left_nxt = '0;
      rec_type_nxt   = '0;
      rec_left_nxt   = '0;
      idx_cnt_nxt    = '0;
      idx_odd_nxt    = 1'b0;
      held_nxt       = '0;
      sh_nxt         = SH_LLEN_HI;
      list_left_nxt  = '0;
      grp_nxt        = '0;
      key_left_nxt   = '0;
      hit_nxt        = 1'b0;
      flags_nxt      = '0;
    end

    unique case (ph_nxt)
      PH_LEN_HI: begin
        block_left_nxt = {b, 8'h00};
        ph_nxt         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        block_left_nxt = {block_left_nxt[15:8], b};
        if (block_left_nxt == '0) begin
          emit = 1'b1;
        end else begin
          ph_nxt = PH_TYPE_HI;
        end
      end
      PH_DONE: begin
      end
      default: begin
        unique case (ph_nxt)
          PH_TYPE_HI: begin
            rec_type_nxt = {b, 8'h00};
            ph_nxt       = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            rec_type_nxt = {rec_type_nxt[15:8], b};
            ph_nxt       = PH_RLEN_HI;
          end
          PH_RLEN_HI: begin
            rec_left_nxt = {b, 8'h00};
            ph_nxt       = PH_RLEN_LO;
          end
          PH_RLEN_LO: begin
            rec_left_nxt  = {rec_left_nxt[15:8], b};
            idx_cnt_nxt   = '0;
            idx_odd_nxt   = 1'b0;
            held_nxt      = '0;
            sh_nxt        = SH_LLEN_HI;
            list_left_nxt = '0;
            grp_nxt       = '0;
            key_left_nxt  = '0;
            hit_nxt       = 1'b0;
            if (rec_type_nxt == EXT_SUPPORTED_GROUPS) flags_nxt[F_GROUP]   = 1'b0;
            if (rec_type_nxt == EXT_POINT_FORMATS)    flags_nxt[F_FORMAT]  = 1'b0;
            if (rec_type_nxt == EXT_SUPPORTED_VERS)   flags_nxt[F_VERSION] = 1'b0;
            if (rec_type_nxt == EXT_PSK_MODES)        flags_nxt[F_PSK]     = 1'b1;
            if (rec_type_nxt == EXT_KEY_SHARE)        flags_nxt[F_SHARE]   = 1'b0;
            ph_nxt = (rec_left_nxt == '0) ? PH_TYPE_HI : PH_BODY;
          end
          default: begin
            // record body byte
            if (rec_type_nxt == EXT_SUPPORTED_GROUPS) begin
              if (idx_cnt_nxt >= 2'd2 && !idx_odd_nxt) begin
                held_nxt = b;
              end else if (idx_cnt_nxt == 2'd3 && held_nxt == 8'h00
                           && {8'h00, b} == GROUP_SECP256R1) begin
                flags_nxt[F_GROUP] = 1'b1;
              end
            end else if (rec_type_nxt == EXT_POINT_FORMATS) begin
              if (idx_cnt_nxt != 2'd0 && b == POINT_UNCOMPRESSED) begin
                flags_nxt[F_FORMAT] = 1'b1;
              end
            end else if (rec_type_nxt == EXT_SUPPORTED_VERS) begin
              if (idx_odd_nxt) begin
                held_nxt = b;
              end else if (idx_cnt_nxt >= 2'd2 && held_nxt == VERSION_MAJOR
                           && b == VERSION_MINOR) begin
                flags_nxt[F_VERSION] = 1'b1;
              end
            end else if (rec_type_nxt == EXT_KEY_SHARE && !hit_nxt) begin
              if (sh_nxt == SH_LLEN_HI) begin
                list_left_nxt = {b, 8'h00};
                sh_nxt        = SH_LLEN_LO;
              end else if (sh_nxt == SH_LLEN_LO) begin
                list_left_nxt = {list_left_nxt[15:8], b};
                sh_nxt        = SH_GRP_HI;
              end else if (sh_nxt == SH_GRP_HI && list_left_nxt == '0) begin
                hit_nxt = 1'b1;
              end else begin
                if (list_left_nxt != '0) list_left_nxt = list_left_nxt - 16'd1;
                unique case (sh_nxt)
                  SH_GRP_HI: begin
                    grp_nxt = {b, 8'h00};
                    sh_nxt  = SH_GRP_LO;
                  end
                  SH_GRP_LO: begin
                    grp_nxt = {grp_nxt[15:8], b};
                    if (grp_nxt == GROUP_X25519) begin
                      flags_nxt[F_SHARE] = 1'b1;
                      hit_nxt            = 1'b1;
                    end else begin
                      sh_nxt = SH_KLEN_HI;
                    end
                  end
                  SH_KLEN_HI: begin
                    key_left_nxt = {b, 8'h00};
                    sh_nxt       = SH_KLEN_LO;
                  end
                  SH_KLEN_LO: begin
                    key_left_nxt = {key_left_nxt[15:8], b};
                    sh_nxt       = (key_left_nxt == '0) ? SH_GRP_HI : SH_KEY_FIRST;
                  end
                  SH_KEY_FIRST: begin
                    if (grp_nxt == GROUP_SECP256R1 && b == KEY_LEAD_BYTE) begin
                      flags_nxt[F_SHARE] = 1'b1;
                      hit_nxt            = 1'b1;
                    end else begin
                      key_left_nxt = key_left_nxt - 16'd1;
                      sh_nxt       = (key_left_nxt == '0) ? SH_GRP_HI : SH_KEY_REST;
                    end
                  end
                  default: begin
                    if (key_left_nxt != '0) key_left_nxt = key_left_nxt - 16'd1;
                    if (key_left_nxt == '0) sh_nxt = SH_GRP_HI;
                  end
                endcase
              end
            end
            if (idx_cnt_nxt != 2'd3) idx_cnt_nxt = idx_cnt_nxt + 2'd1;
            idx_odd_nxt  = !idx_odd_nxt;
            rec_left_nxt = rec_left_nxt - 16'd1;
            if (rec_left_nxt == '0) ph_nxt = PH_TYPE_HI;
          end
        endcase
        block_left_nxt = block_left_nxt - 16'd1;
        if (block_left_nxt == '0) emit = 1'b1;
      end
    endcase

    if (emit) ph_nxt = PH_DONE;
  end

  assign res = '{valid: fire && emit, flags: flags_nxt};

endmodule

[sv/tecc_out_reg.sv]
// Result register stage of the extension capability checker; drives the output channel.
// Depends on tecc_pkg and tecc_out_if.
`timescale 1ns / 1ps

module tecc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  tecc_pkg::result_t res,
  output logic              adv,
  tecc_out_if.source        out_if
);
  import tecc_pkg::*;

  logic   valid_r;
  flags_t flags_r;

  assign adv = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      flags_r <= res.flags;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.accept        = &flags_r;
  assign out_if.group_ok      = flags_r[F_GROUP];
  assign out_if.format_ok     = flags_r[F_FORMAT];
  assign out_if.version_ok    = flags_r[F_VERSION];
  assign out_if.psk_mode_seen = flags_r[F_PSK];
  assign out_if.share_ok      = flags_r[F_SHARE];

endmodule

[sv/tls13_extension_capability_check.sv]
// TLS 1.3 ClientHello extension capability checker. Takes one extension-block
// byte per cycle (a new byte may enter every cycle unless an unread result stalls
// the input), walks the type/length records and reports five capability flags
// plus their AND once the declared 16-bit total length is consumed; bytes after
// that are dropped until a byte with block_start restarts the parser. A result
// becomes valid once the byte that completes the block has passed through the
// input register and one pass of parse logic into the result register.
// Input ready falls only while a result is held unread.
// Depends on tecc_pkg, tecc_if, tecc_in_reg, tecc_parser and tecc_out_reg.
`timescale 1ns / 1ps

module tls13_extension_capability_check (
  input  logic        clk,
  input  logic        rst_n,
  tecc_in_if.sink     in_if,
  tecc_out_if.source  out_if
);
  import tecc_pkg::*;

  item_t   item;
  result_t res;
  logic    adv;

  tecc_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .item  (item)
  );

  tecc_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .adv   (adv),
    .res   (res)
  );

  tecc_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .adv    (adv),
    .out_if (out_if)
  );

endmodule

[sv/tecc_checker.sv]
// Port-level checks for the extension capability checker, bound to the top level.
// Depends on tls13_extension_capability_check.
`timescale 1ns / 1ps

module tecc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_accept,
  input logic out_group_ok,
  input logic out_format_ok,
  input logic out_version_ok,
  input logic out_psk_mode_seen,
  input logic out_share_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_accept) && $stable(out_group_ok) && $stable(out_format_ok)
      && $stable(out_version_ok) && $stable(out_psk_mode_seen)
      && $stable(out_share_ok))
    else $error("stalled result transaction changed");

  a_accept_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accept == (out_group_ok && out_format_ok
      && out_version_ok && out_psk_mode_seen && out_share_ok))
    else $error("accept disagrees with capability flags");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

bind tls13_extension_capability_check tecc_checker u_tecc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_accept        (out_if.accept),
  .out_group_ok      (out_if.group_ok),
  .out_format_ok     (out_if.format_ok),
  .out_version_ok    (out_if.version_ok),
  .out_psk_mode_seen (out_if.psk_mode_seen),
  .out_share_ok      (out_if.share_ok)
);

[tb/tls13_extension_capability_check_tb.sv]
// Testbench for tls13_extension_capability_check: drives extension blocks byte by byte,
// predicts the capability flags of each block and checks every result against them.
// Depends on tecc_pkg, tecc_if and the checker RTL.
`timescale 1ns / 1ps

module tls13_extension_capability_check_tb;
  import tecc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic rx_hold = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;
  int bytes_sent = 0;
  int unsigned cycle_count = 0;

  logic [7:0] pkt[$];
  logic [7:0] rec_body[$];
  flags_t expected_caps[$];

  // predicted parser state
  parse_phase_t walk_phase;
  logic [15:0] bytes_left;
  logic [15:0] ext_type;
  logic [15:0] ext_left;
  logic [15:0] ext_pos;
  logic [7:0] pend_byte;
  share_phase_t ks_phase;
  logic [15:0] ks_list;
  logic [15:0] ks_group;
  logic [15:0] ks_key;
  logic ks_done;
  flags_t caps;

  tecc_in_if in_ch ();
  tecc_out_if out_ch ();

  tls13_extension_capability_check u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tls13_extension_capability_check test failed");
      $finish;
    end
  end

  function automatic void clear_walk();
    walk_phase = PH_LEN_HI;
    bytes_left = '0;
    ext_type = '0;
    ext_left = '0;
    ext_pos = '0;
    pend_byte = '0;
    ks_phase = SH_LLEN_HI;
    ks_list = '0;
    ks_group = '0;
    ks_key = '0;
    ks_done = 1'b0;
    caps = '0;
  endfunction

  function automatic void open_ext();
    ext_pos = '0;
    pend_byte = '0;
    ks_phase = SH_LLEN_HI;
    ks_list = '0;
    ks_group = '0;
    ks_key = '0;
    ks_done = 1'b0;
    case (ext_type)
      EXT_SUPPORTED_GROUPS: caps[F_GROUP] = 1'b0;
      EXT_POINT_FORMATS:    caps[F_FORMAT] = 1'b0;
      EXT_SUPPORTED_VERS:   caps[F_VERSION] = 1'b0;
      EXT_PSK_MODES:        caps[F_PSK] = 1'b1;
      EXT_KEY_SHARE:        caps[F_SHARE] = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void share_walk_byte(input logic [7:0] b);
    if (ks_done) return;
    if (ks_phase == SH_LLEN_HI) begin
      ks_list = {b, 8'h00};
      ks_phase = SH_LLEN_LO;
    end else if (ks_phase == SH_LLEN_LO) begin
      ks_list[7:0] = b;
      ks_phase = SH_GRP_HI;
    end else if (ks_phase == SH_GRP_HI && ks_list == 0) begin
      ks_done = 1'b1;
    end else begin
      if (ks_list != 0) ks_list = ks_list - 16'd1;
      case (ks_phase)
        SH_GRP_HI: begin
          ks_group = {b, 8'h00};
          ks_phase = SH_GRP_LO;
        end
        SH_GRP_LO: begin
          ks_group[7:0] = b;
          if (ks_group == GROUP_X25519) begin
            caps[F_SHARE] = 1'b1;
            ks_done = 1'b1;
          end else begin
            ks_phase = SH_KLEN_HI;
          end
        end
        SH_KLEN_HI: begin
          ks_key = {b, 8'h00};
          ks_phase = SH_KLEN_LO;
        end
        SH_KLEN_LO: begin
          ks_key[7:0] = b;
          ks_phase = (ks_key == 0) ? SH_GRP_HI : SH_KEY_FIRST;
        end
        SH_KEY_FIRST: begin
          if (ks_group == GROUP_SECP256R1 && b == KEY_LEAD_BYTE) begin
            caps[F_SHARE] = 1'b1;
            ks_done = 1'b1;
          end else begin
            ks_key = ks_key - 16'd1;
            ks_phase = (ks_key == 0) ? SH_GRP_HI : SH_KEY_REST;
          end
        end
        default: begin
          if (ks_key != 0) ks_key = ks_key - 16'd1;
          if (ks_key == 0) ks_phase = SH_GRP_HI;
        end
      endcase
    end
  endfunction

  function automatic void ext_body_byte(input logic [7:0] b);
    case (ext_type)
      EXT_SUPPORTED_GROUPS: begin
        if (ext_pos >= 2 && !ext_pos[0]) pend_byte = b;
        else if (ext_pos >= 3 && pend_byte == GROUP_SECP256R1[15:8] &&
                 b == GROUP_SECP256R1[7:0]) caps[F_GROUP] = 1'b1;
      end
      EXT_POINT_FORMATS: begin
        if (ext_pos >= 1 && b == POINT_UNCOMPRESSED) caps[F_FORMAT] = 1'b1;
      end
      EXT_SUPPORTED_VERS: begin
        if (ext_pos[0]) pend_byte = b;
        else if (ext_pos >= 2 && pend_byte == VERSION_MAJOR && b == VERSION_MINOR)
          caps[F_VERSION] = 1'b1;
      end
      EXT_KEY_SHARE: share_walk_byte(b);
      default: ;
    endcase
    ext_pos = ext_pos + 16'd1;
    ext_left = ext_left - 16'd1;
    if (ext_left == 0) walk_phase = PH_TYPE_HI;
  endfunction

  // Returns 1 when the byte completes a block; res then holds its flags.
  function automatic bit predict_caps(input logic [7:0] b, input logic st, output flags_t res);
    res = '0;
    if (st) clear_walk();
    case (walk_phase)
      PH_LEN_HI: begin
        bytes_left = {b, 8'h00};
        walk_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        bytes_left[7:0] = b;
        if (bytes_left == 0) begin
          res = caps;
          walk_phase = PH_DONE;
          return 1'b1;
        end
        walk_phase = PH_TYPE_HI;
        return 1'b0;
      end
      PH_DONE: return 1'b0;
      PH_TYPE_HI: begin
        ext_type = {b, 8'h00};
        walk_phase = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        ext_type[7:0] = b;
        walk_phase = PH_RLEN_HI;
      end
      PH_RLEN_HI: begin
        ext_left = {b, 8'h00};
        walk_phase = PH_RLEN_LO;
      end
      PH_RLEN_LO: begin
        ext_left[7:0] = b;
        open_ext();
        walk_phase = (ext_left == 0) ? PH_TYPE_HI : PH_BODY;
      end
      default: ext_body_byte(b);
    endcase
    bytes_left = bytes_left - 16'd1;
    if (bytes_left == 0) begin
      res = caps;
      walk_phase = PH_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("ERROR cycle %0d: %s got %0b expected %0b", cycle_count, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    flags_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_caps.size() == 0) begin
        report_mismatch("result with no pending block", 1'b1, 1'b0);
      end else begin
        want = expected_caps.pop_front();
        if (out_ch.accept !== (&want)) report_mismatch("accept", out_ch.accept, &want);
        if (out_ch.group_ok !== want[F_GROUP])
          report_mismatch("group_ok", out_ch.group_ok, want[F_GROUP]);
        if (out_ch.format_ok !== want[F_FORMAT])
          report_mismatch("format_ok", out_ch.format_ok, want[F_FORMAT]);
        if (out_ch.version_ok !== want[F_VERSION])
          report_mismatch("version_ok", out_ch.version_ok, want[F_VERSION]);
        if (out_ch.psk_mode_seen !== want[F_PSK])
          report_mismatch("psk_mode_seen", out_ch.psk_mode_seen, want[F_PSK]);
        if (out_ch.share_ok !== want[F_SHARE])
          report_mismatch("share_ok", out_ch.share_ok, want[F_SHARE]);
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic hold_receiver();
    rx_hold <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    flags_t res;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.block_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if (predict_caps(b, st, res)) expected_caps.insert(expected_caps.size(), res);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (expected_caps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic put8(input logic [7:0] b);
    rec_body.insert(rec_body.size(), b);
  endtask

  task automatic put16(input logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endtask

  task automatic add_pkt(input logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endtask

  // wrap the collected body into a record
  task automatic put_rec(input logic [15:0] t);
    logic [15:0] n;
    n = 16'(rec_body.size());
    add_pkt(t[15:8]);
    add_pkt(t[7:0]);
    add_pkt(n[15:8]);
    add_pkt(n[7:0]);
    foreach (rec_body[i]) add_pkt(rec_body[i]);
    rec_body.delete();
  endtask

  task automatic send_framed(input logic [15:0] len, input logic mark);
    send_byte(len[15:8], mark);
    send_byte(len[7:0], 1'b0);
    foreach (pkt[i]) send_byte(pkt[i], 1'b0);
    pkt.delete();
  endtask

  function automatic logic [15:0] pick_group();
    case ($urandom_range(4))
      0: return GROUP_SECP256R1;
      1: return GROUP_X25519;
      2: return GROUP_SECP256R1 | 16'h0100;
      3: return 16'($urandom_range(255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_known_ext();
    case ($urandom_range(4))
      0: return EXT_SUPPORTED_GROUPS;
      1: return EXT_POINT_FORMATS;
      2: return EXT_SUPPORTED_VERS;
      3: return EXT_PSK_MODES;
      default: return EXT_KEY_SHARE;
    endcase
  endfunction

  task automatic add_random_record();
    logic [7:0] ents[$];
    logic [15:0] g;
    int n;
    int k;
    case ($urandom_range(9))
      0, 1: begin
        n = $urandom_range(3);
        put16(($urandom_range(7) == 0) ? 16'($urandom_range(9)) : 16'(2 * n));
        repeat (n) put16(pick_group());
        if ($urandom_range(3) == 0) put8(8'($urandom()));
        put_rec(EXT_SUPPORTED_GROUPS);
      end
      2: begin
        n = $urandom_range(3);
        put8(8'(n));
        repeat (n) put8(($urandom_range(2) == 0) ? POINT_UNCOMPRESSED : 8'($urandom()));
        put_rec(EXT_POINT_FORMATS);
      end
      3: begin
        n = $urandom_range(3);
        put8(8'(2 * n));
        repeat (n) begin
          case ($urandom_range(3))
            0: begin put8(VERSION_MAJOR); put8(VERSION_MINOR); end
            1: begin put8(VERSION_MAJOR); put8(8'($urandom())); end
            2: begin put8(8'($urandom())); put8(VERSION_MINOR); end
            default: put16(16'($urandom()));
          endcase
        end
        if ($urandom_range(3) == 0) put8(8'($urandom()));
        put_rec(EXT_SUPPORTED_VERS);
      end
      4: begin
        repeat ($urandom_range(3)) put8(8'($urandom()));
        put_rec(EXT_PSK_MODES);
      end
      5, 6: begin
        repeat ($urandom_range(2)) begin
          g = pick_group();
          k = $urandom_range(3);
          ents.insert(ents.size(), g[15:8]);
          ents.insert(ents.size(), g[7:0]);
          ents.insert(ents.size(), 8'h00);
          ents.insert(ents.size(), 8'(k));
          if (k > 0)
            ents.insert(ents.size(),
                        ($urandom_range(1) == 0) ? KEY_LEAD_BYTE : 8'($urandom()));
          repeat (k - 1) ents.insert(ents.size(), 8'($urandom()));
        end
        put16(($urandom_range(5) == 0) ? 16'($urandom_range(ents.size())) : 16'(ents.size()));
        foreach (ents[i]) put8(ents[i]);
        put_rec(EXT_KEY_SHARE);
      end
      7: begin
        repeat ($urandom_range(5)) put8(8'($urandom()));
        put_rec(($urandom_range(1) == 0) ? 16'($urandom()) : (pick_known_ext() | 16'h0100));
      end
      8: put_rec(pick_known_ext());
      default: begin
        repeat ($urandom_range(6)) put8(8'($urandom()));
        put_rec(pick_known_ext());
      end
    endcase
  endtask

  task automatic send_random_block();
    int mode;
    int len;
    mode = $urandom_range(99);
    if (mode < 5) begin
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom()), ($urandom_range(7) == 0));
      return;
    end
    repeat ($urandom_range(5)) add_random_record();
    len = pkt.size();
    if (mode < 12 && len > 0) len = $urandom_range(len - 1);
    else if (mode < 16) len = len + $urandom_range(4, 1);
    send_framed(16'(len), ($urandom_range(19) != 0));
    if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom()), 1'b0);
  endtask

  task automatic test_start_without_mark();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
  endtask

  task automatic test_full_accept();
    put16(16'h0002);
    put16(GROUP_SECP256R1);
    put_rec(EXT_SUPPORTED_GROUPS);
    put8(8'h01);
    put8(POINT_UNCOMPRESSED);
    put_rec(EXT_POINT_FORMATS);
    put8(8'h02);
    put8(VERSION_MAJOR);
    put8(VERSION_MINOR);
    put_rec(EXT_SUPPORTED_VERS);
    put8(8'h01);
    put8(8'h01);
    put_rec(EXT_PSK_MODES);
    put16(16'h0006);
    put16(GROUP_SECP256R1);
    put16(16'h0002);
    put8(KEY_LEAD_BYTE);
    put8(8'hAA);
    put_rec(EXT_KEY_SHARE);
    send_framed(16'(pkt.size()), 1'b1);
  endtask

  task automatic test_overwrite_and_empty();
    put16(16'h0002);
    put16(GROUP_X25519);
    put_rec(EXT_KEY_SHARE);
    put16(16'h0002);
    put16(GROUP_SECP256R1);
    put_rec(EXT_SUPPORTED_GROUPS);
    put_rec(EXT_SUPPORTED_GROUPS);
    put_rec(EXT_PSK_MODES);
    put_rec(EXT_POINT_FORMATS);
    put16(16'h0002);
    put16(GROUP_SECP256R1);
    put_rec(EXT_SUPPORTED_GROUPS | 16'h0100);
    put16(16'hFFFF);
    put8(8'hFF);
    put_rec(16'hFFFF);
    send_framed(16'(pkt.size()), 1'b1);
  endtask

  task automatic test_cut_short();
    // version flag set before the cut, trailing bytes dropped
    put8(8'h04);
    put8(VERSION_MAJOR);
    put8(VERSION_MINOR);
    put8(VERSION_MAJOR);
    put8(8'h03);
    put_rec(EXT_SUPPORTED_VERS);
    send_framed(16'd7, 1'b1);
    // record header cut short
    put_rec(EXT_PSK_MODES);
    send_framed(16'd3, 1'b1);
  endtask

  task automatic test_odd_lists();
    put16(16'h0002);
    put8(8'h00);
    put_rec(EXT_SUPPORTED_GROUPS);
    put8(VERSION_MAJOR);
    put8(VERSION_MINOR);
    put_rec(EXT_SUPPORTED_VERS);
    put8(POINT_UNCOMPRESSED);
    put_rec(EXT_POINT_FORMATS);
    send_framed(16'(pkt.size()), 1'b1);
  endtask

  task automatic test_share_edges();
    // empty key, then an entry that runs past the list end
    put16(16'h0005);
    put16(GROUP_SECP256R1);
    put16(16'h0000);
    put16(GROUP_SECP256R1);
    put16(16'h0002);
    put8(KEY_LEAD_BYTE);
    put8(8'h00);
    put_rec(EXT_KEY_SHARE);
    send_framed(16'(pkt.size()), 1'b1);
    // exhausted list, then wrong lead byte followed by x25519
    put16(16'h0000);
    put16(GROUP_X25519);
    put_rec(EXT_KEY_SHARE);
    put16(16'h0008);
    put16(GROUP_SECP256R1);
    put16(16'h0001);
    put8(8'h05);
    put16(GROUP_X25519);
    put_rec(EXT_KEY_SHARE);
    send_framed(16'(pkt.size()), 1'b1);
  endtask

  task automatic test_restart_midblock();
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_receiver();
    repeat (40) begin
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
    end
    wait_results_drained();
  endtask

  task automatic run_random_phase(input int idle, input int stall, input int n_bytes);
    int stop_at;
    idle_pct = idle;
    stall_pct = stall;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_block();
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 280);
    run_random_phase(46, 0, 280);
    run_random_phase(0, 46, 280);
    run_random_phase(13, 13, 280);
  endtask

  initial begin
    clear_walk();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.block_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_start_without_mark();
    test_full_accept();
    test_overwrite_and_empty();
    test_cut_short();
    test_odd_lists();
    test_share_edges();
    test_restart_midblock();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    if (err_count == 0) begin
      $display("tls13_extension_capability_check test passed");
    end else begin
      $display("tls13_extension_capability_check test failed");
    end
    $finish;
  end

endmodule
